@@ rtl/sibl_pkg.sv @@
// Shared types and constants for the scale-invariant BerHu loss block.
// Used by every module under rtl; depends on nothing.
package sibl_pkg;

  typedef enum logic [3:0] {
    ST_LOAD, ST_BASE, ST_MEAN, ST_THR, ST_PASS, ST_DRAIN,
    ST_CHK, ST_T1, ST_SQ, ST_WT, ST_T2, ST_DONE
  } state_t;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_MIN     = 3'd1;
  localparam logic [2:0] CFG_MAX     = 3'd2;
  localparam logic [2:0] CFG_LRATE   = 3'd3;
  localparam logic [2:0] CFG_URATE   = 3'd4;
  localparam logic [2:0] CFG_DBAND   = 3'd5;
  localparam logic [2:0] CFG_WEIGHT  = 3'd6;

  localparam int MODE_AVG    = 0;
  localparam int MODE_RANGE  = 1;
  localparam int MODE_ADJUST = 2;
  localparam int MODE_UPPER  = 3;

  localparam int DIFF_W  = 33;
  localparam int ENTRY_W = 34;
  localparam int CLAMP_W = 34;
  localparam int SQ_W    = 66;
  localparam int NUM_W   = 128;
  localparam int DEN_W   = 64;

  localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [3:0]  MODE_RST   = 4'd4;
  localparam logic [31:0] MIN_RST    = 32'd1;
  localparam logic [31:0] MAX_RST    = 32'h7FFF_FFFF;
  localparam logic [15:0] LRATE_RST  = 16'd13107;

endpackage

@@ rtl/sibl_store.sv @@
// Difference store: one synchronous memory of {valid mark, difference}.
// Uses sibl_pkg for the entry width.
module sibl_store #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [sibl_pkg::ENTRY_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [sibl_pkg::ENTRY_W-1:0] rdata
);
  import sibl_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sibl_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle.
// Uses sibl_pkg for operand widths.
module sibl_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sibl_pkg::NUM_W-1:0] a,
  input  logic [sibl_pkg::DEN_W-1:0] b,
  output logic                       done,
  output logic [sibl_pkg::NUM_W-1:0] prod
);
  import sibl_pkg::*;

  logic             busy_r;
  logic [NUM_W-1:0] acc_r;
  logic [NUM_W-1:0] a_r;
  logic [DEN_W-1:0] b_r;

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[NUM_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[DEN_W-1:1]};
    end
  end

endmodule

@@ rtl/sibl_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating at 2^63-1.
// Uses sibl_pkg for widths and the saturation constant.
module sibl_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sibl_pkg::NUM_W-1:0] numer,
  input  logic [sibl_pkg::DEN_W-1:0] denom,
  output logic                       done,
  output logic [sibl_pkg::DEN_W-1:0] quot
);
  import sibl_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [6:0]       cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] lo_r;
  logic [DEN_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic             early;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign early = (denom == '0) || (numer[NUM_W-1:DEN_W] >= denom);
  assign trial = {rem_r, lo_r[DEN_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quot  = (q_r > SAT63) ? SAT63 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= start ? early : (busy_r && (cnt_r == 7'd1));
      if (start) begin
        busy_r <= !early;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[NUM_W-1:DEN_W];
      lo_r  <= numer[DEN_W-1:0];
      den_r <= denom;
      q_r   <= early ? SAT63 : '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r  <= {lo_r[DEN_W-2:0], 1'b0};
      q_r   <= {q_r[DEN_W-2:0], ge};
    end
  end

endmodule

@@ rtl/scale_invariant_berhu_loss.sv @@
// Scale-invariant BerHu loss, top level: load sequencer, store pass, loss assembly.
// Depends on sibl_pkg, sibl_store, sibl_mul and sibl_div.
//
// Usage: pixels arrive on the in_ stream, one transaction per pixel, at one per
// cycle while loading. in_tlast closes a sample, in_tuser[0] closes the batch.
// Each pixel's difference and valid mark are written to the difference memory
// while the batch has room for it. After the batch-closing pixel in_tready drops
// while the compute pass runs: an optional mean division, a threshold step, a
// read pass over the memory at one pixel a cycle with a pipeline drain after
// each sample, then one division for the squared term and, per sample, two
// shift-add multiplies and one division.
// The divider and the multiplier are each a single shared unit.
// The result leaves on out_ as one transaction; an output register holds it,
// and the next batch is loaded while it waits. A stalled receiver only delays
// the next batch's compute end. Configuration writes on cfg_ are always taken.
// Reset is synchronous, active low; it clears counters and restores registers.
// No clearing pass: only entries written in the current batch are read.
module scale_invariant_berhu_loss #(
  parameter int MAX_SAMPLES           = 8,
  parameter int MAX_PIXELS_PER_SAMPLE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // prediction[31:0], label[63:32]
  input  logic        in_tlast,   // last_in_sample
  input  logic [0:0]  in_tuser,   // last_in_batch[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // loss[62:0], valid_total[78:63], zero[79]
  output logic [0:0]  out_tuser,  // divide_by_zero[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sibl_pkg::*;

  localparam int MS    = MAX_SAMPLES;
  localparam int MPPS  = MAX_PIXELS_PER_SAMPLE;
  localparam int DEPTH = MS * MPPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCW   = $clog2(MS + 1);
  localparam int SIW   = (MS > 1) ? $clog2(MS) : 1;
  localparam int PCW   = $clog2(MPPS + 1);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int SUMW  = DIFF_W + TW;
  localparam int SSW   = CLAMP_W + PCW;
  localparam int DOTW  = SQ_W + TW;
  localparam int VVW   = 2 * PCW;
  localparam int DENW  = VVW + SCW;

  state_t state_r, state_nxt;

  logic [3:0]         mode_r;
  logic signed [31:0] minl_r, maxl_r;
  logic [15:0]        lrate_r;
  logic [23:0]        urate_r;
  logic [30:0]        dband_r;
  logic [23:0]        wt_r;

  logic [SCW-1:0]  s_r;
  logic [PCW-1:0]  cur_size_r, cur_valid_r;
  logic [AW-1:0]   sbase_r;
  logic [TW-1:0]   pix_r;
  logic [DIFF_W-1:0] max_r;
  logic [SUMW-1:0] sum_r;
  logic [PCW-1:0]  size_arr [MS];
  logic [PCW-1:0]  vcnt_arr [MS];
  logic signed [SSW-1:0] sums_arr [MS];

  logic [SCW-1:0]  n_r;
  logic [PCW-1:0]  k_r;
  logic [AW-1:0]   rbase_r;
  logic [TW:0]     tv_r;
  logic            zero_r;
  logic            dbz_r;
  logic            p1_r, p2_r, p3_r;
  logic signed [CLAMP_W-1:0] dc_r;
  logic [SQ_W-1:0] sq_r;
  logic signed [SSW-1:0] ssum_r;
  logic [DOTW-1:0] dot_r;
  logic [63:0]     loss_r;
  logic [DIFF_W-1:0] base_r, cth_r;
  logic [40:0]     hth_r;
  logic [VVW-1:0]  vv_r;
  logic [DENW-1:0] den_r;

  logic            out_valid_r;
  logic [62:0]     out_loss_r;
  logic [15:0]     out_vt_r;
  logic            out_dbz_r;

  logic in_fire, s_ok, store_en, close, lab_ok;
  logic signed [31:0] pred, lab;
  logic signed [DIFF_W-1:0] diff_in;
  logic [DIFF_W-1:0] ad_in;
  logic [SIW-1:0] s_idx, n_idx;
  logic [ENTRY_W-1:0] rdata;
  logic rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [PCW-1:0] cur_sz, v_n;
  logic adjust_on, drained;
  logic signed [DIFF_W-1:0] rd_d, db_s;
  logic [DIFF_W-1:0] rd_ad;
  logic signed [CLAMP_W-1:0] dc_c, dc_mag;
  logic signed [SSW-1:0] s_sel;
  logic [SSW-1:0] s_mag;
  logic [48:0] prod_c;
  logic [56:0] prod_h;
  logic [63:0] tsum;

  logic div_start, div_done, mul_start, mul_done;
  logic [NUM_W-1:0] div_numer, mul_a, mul_prod;
  logic [DEN_W-1:0] div_denom, div_quot, mul_b;

  assign pred     = in_tdata[31:0];
  assign lab      = in_tdata[63:32];
  assign in_fire  = in_tvalid && in_tready;
  assign s_ok     = s_r < SCW'(MS);
  assign store_en = in_fire && s_ok && (cur_size_r < PCW'(MPPS));
  assign close    = in_fire && (in_tlast || in_tuser[0]) && s_ok;
  assign diff_in  = {pred[31], pred} - {lab[31], lab};
  assign ad_in    = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);
  assign lab_ok   = (lab >= minl_r) && (lab <= maxl_r);
  assign s_idx    = s_r[SIW-1:0];
  assign n_idx    = n_r[SIW-1:0];
  assign waddr    = sbase_r + AW'(cur_size_r);
  assign raddr    = rbase_r + AW'(k_r);

  assign adjust_on = mode_r[MODE_RANGE] && mode_r[MODE_ADJUST];
  assign cur_sz    = size_arr[n_idx];
  assign v_n       = adjust_on ? vcnt_arr[n_idx] : size_arr[n_idx];
  assign drained   = !p1_r && !p2_r && !p3_r;
  assign s_sel     = sums_arr[n_idx];
  assign s_mag     = s_sel[SSW-1] ? SSW'(-s_sel) : SSW'(s_sel);
  assign prod_c    = base_r * lrate_r;
  assign prod_h    = base_r * urate_r;
  assign tsum      = loss_r + div_quot;

  assign in_tready  = (state_r == ST_LOAD);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_vt_r, out_loss_r};
  assign out_tuser  = out_dbz_r;

  sibl_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (waddr),
    .wdata ({lab_ok, diff_in}),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  sibl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sibl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign rd_d  = rdata[DIFF_W-1:0];
  assign rd_ad = rd_d[DIFF_W-1] ? DIFF_W'(-rd_d) : DIFF_W'(rd_d);
  assign db_s  = {2'b00, dband_r};

  always_comb begin
    dc_c = CLAMP_W'(rd_d);
    if (mode_r[MODE_RANGE]) begin
      if (!rdata[ENTRY_W-1]) begin
        dc_c = '0;
      end else if (rd_ad <= cth_r) begin
        if (rd_d > db_s) begin
          dc_c = {1'b0, cth_r};
        end else if (rd_d < -db_s) begin
          dc_c = -$signed({1'b0, cth_r});
        end
      end else if (mode_r[MODE_UPPER] && ({8'd0, rd_ad} > hth_r)) begin
        dc_c = rd_d[DIFF_W-1] ? -$signed({1'b0, hth_r[DIFF_W-1:0]})
                              : $signed({1'b0, hth_r[DIFF_W-1:0]});
      end
    end
  end

  assign dc_mag = dc_r[CLAMP_W-1] ? -dc_r : dc_r;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_numer = '0;
    div_denom = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rd_en     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_tuser[0]) state_nxt = ST_BASE;
      end
      ST_BASE: begin
        if (mode_r[MODE_AVG] && (pix_r != '0)) begin
          div_start = 1'b1;
          div_numer = NUM_W'(sum_r);
          div_denom = DEN_W'(pix_r);
          state_nxt = ST_MEAN;
        end else begin
          state_nxt = ST_THR;
        end
      end
      ST_MEAN: begin
        if (div_done) state_nxt = ST_THR;
      end
      ST_THR: begin
        state_nxt = (s_r == '0) ? ST_CHK : ST_PASS;
      end
      ST_PASS: begin
        if (k_r < cur_sz) begin
          rd_en = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) state_nxt = ((n_r + SCW'(1)) == s_r) ? ST_CHK : ST_PASS;
      end
      ST_CHK: begin
        if ((tv_r == '0) || zero_r) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_numer = NUM_W'(dot_r);
          div_denom = DEN_W'({tv_r, 1'b0});
          state_nxt = ST_T1;
        end
      end
      ST_T1: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = NUM_W'(s_mag);
          mul_b     = DEN_W'(s_mag);
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = DEN_W'(wt_r);
          state_nxt = ST_WT;
        end
      end
      ST_WT: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_numer = mul_prod;
          div_denom = DEN_W'({den_r, 17'd0});
          state_nxt = ST_T2;
        end
      end
      ST_T2: begin
        if (div_done) begin
          if (n_r == s_r) begin
            state_nxt = ST_DONE;
          end else begin
            mul_start = 1'b1;
            mul_a     = NUM_W'(s_mag);
            mul_b     = DEN_W'(s_mag);
            state_nxt = ST_SQ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      mode_r      <= MODE_RST;
      minl_r      <= MIN_RST;
      maxl_r      <= MAX_RST;
      lrate_r     <= LRATE_RST;
      urate_r     <= '0;
      dband_r     <= '0;
      wt_r        <= '0;
      s_r         <= '0;
      cur_size_r  <= '0;
      cur_valid_r <= '0;
      sbase_r     <= '0;
      pix_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      for (int i = 0; i < MS; i++) begin
        size_arr[i] <= '0;
        vcnt_arr[i] <= '0;
      end
      n_r         <= '0;
      k_r         <= '0;
      rbase_r     <= '0;
      tv_r        <= '0;
      zero_r      <= 1'b0;
      dbz_r       <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      ssum_r      <= '0;
      dot_r       <= '0;
      loss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_MODE:   mode_r  <= cfg_data[3:0];
          CFG_MIN:    minl_r  <= cfg_data;
          CFG_MAX:    maxl_r  <= cfg_data;
          CFG_LRATE:  lrate_r <= cfg_data[15:0];
          CFG_URATE:  urate_r <= cfg_data[23:0];
          CFG_DBAND:  dband_r <= cfg_data[30:0];
          CFG_WEIGHT: wt_r    <= cfg_data[23:0];
          default: ;
        endcase
      end

      if (store_en) begin
        pix_r <= pix_r + TW'(1);
        if (ad_in > max_r) max_r <= ad_in;
        sum_r <= sum_r + SUMW'(ad_in);
      end
      if (close) begin
        size_arr[s_idx] <= cur_size_r + PCW'(store_en);
        vcnt_arr[s_idx] <= cur_valid_r + PCW'(store_en && lab_ok);
        s_r             <= s_r + SCW'(1);
        cur_size_r      <= '0;
        cur_valid_r     <= '0;
        sbase_r         <= sbase_r + AW'(MPPS);
      end else if (store_en) begin
        cur_size_r <= cur_size_r + PCW'(1);
        if (lab_ok) cur_valid_r <= cur_valid_r + PCW'(1);
      end

      p1_r <= rd_en;
      p2_r <= p1_r;
      p3_r <= p2_r;
      if (rd_en) k_r <= k_r + PCW'(1);
      if (p2_r) ssum_r <= ssum_r + SSW'(dc_r);
      if (p3_r) dot_r <= dot_r + DOTW'(sq_r);

      case (state_r)
        ST_THR: begin
          n_r     <= '0;
          k_r     <= '0;
          rbase_r <= '0;
          tv_r    <= '0;
          zero_r  <= 1'b0;
          dbz_r   <= 1'b0;
          ssum_r  <= '0;
          dot_r   <= '0;
        end
        ST_DRAIN: begin
          if (drained) begin
            tv_r    <= tv_r + (TW+1)'(v_n);
            if (v_n == '0) zero_r <= 1'b1;
            n_r     <= n_r + SCW'(1);
            k_r     <= '0;
            rbase_r <= rbase_r + AW'(MPPS);
            ssum_r  <= '0;
          end
        end
        ST_CHK: begin
          n_r <= '0;
          if ((tv_r == '0) || zero_r) begin
            dbz_r  <= 1'b1;
            loss_r <= SAT63;
          end
        end
        ST_T1: begin
          if (div_done) loss_r <= div_quot;
        end
        ST_WT: begin
          if (mul_done) n_r <= n_r + SCW'(1);
        end
        ST_T2: begin
          if (div_done) loss_r <= (tsum > SAT63) ? SAT63 : tsum;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            s_r         <= '0;
            cur_size_r  <= '0;
            cur_valid_r <= '0;
            sbase_r     <= '0;
            pix_r       <= '0;
            max_r       <= '0;
            sum_r       <= '0;
            for (int i = 0; i < MS; i++) begin
              size_arr[i] <= '0;
              vcnt_arr[i] <= '0;
            end
          end
        end
        default: ;
      endcase

      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vv_r <= v_n * v_n;
    if (p1_r) dc_r <= dc_c;
    if (p2_r) sq_r <= dc_mag[DIFF_W-1:0] * dc_mag[DIFF_W-1:0];
    case (state_r)
      ST_BASE: begin
        if (!(mode_r[MODE_AVG] && (pix_r != '0))) begin
          base_r <= mode_r[MODE_AVG] ? '0 : max_r;
        end
      end
      ST_MEAN: begin
        if (div_done) base_r <= div_quot[DIFF_W-1:0];
      end
      ST_THR: begin
        cth_r <= prod_c[48:16];
        hth_r <= prod_h[56:16];
      end
      ST_DRAIN: begin
        if (drained) sums_arr[n_idx] <= ssum_r;
      end
      ST_SQ: begin
        if (mul_done) den_r <= DENW'(vv_r) * DENW'(s_r);
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_loss_r <= loss_r[62:0];
          out_vt_r   <= 16'(tv_r);
          out_dbz_r  <= dbz_r;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/scale_invariant_berhu_loss_tb.sv @@
`timescale 1ns / 1ps
// Testbench for scale_invariant_berhu_loss: streams random and directed pixel batches,
// predicts each batch loss in a scoreboard class and checks every result transaction.
// Depends on sibl_pkg and the scale_invariant_berhu_loss RTL.
module scale_invariant_berhu_loss_tb;
  import sibl_pkg::*;

  localparam int NSAMP = 8;
  localparam int NPIX  = 4096;
  localparam logic [63:0] SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit [62:0] loss;
    bit [15:0] valid_total;
    bit        dbz;
  } batch_loss_t;

  class loss_scoreboard;
    longint    diffs[NSAMP*NPIX];
    bit        marks[NSAMP*NPIX];
    int        vcnt[NSAMP];
    int        sizes[NSAMP];
    bit [63:0] max_abs;
    bit [63:0] abs_sum;
    int        pix_cnt;
    int        samp_cnt;
    bit [3:0]  mode;
    int        min_lab;
    int        max_lab;
    bit [63:0] lrate, urate, dband, weight;
    batch_loss_t losses[$];
    int        errors, results, dbz_seen;

    function new();
      mode = MODE_RST;
      min_lab = MIN_RST;
      max_lab = MAX_RST;
      lrate = LRATE_RST;
      urate = 0;
      dband = 0;
      weight = 0;
      clear();
    endfunction

    function void clear();
      foreach (vcnt[i]) begin
        vcnt[i] = 0;
        sizes[i] = 0;
      end
      max_abs = 0;
      abs_sum = 0;
      pix_cnt = 0;
      samp_cnt = 0;
    endfunction

    function void configure(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_MODE:   mode = data[3:0];
        CFG_MIN:    min_lab = data;
        CFG_MAX:    max_lab = data;
        CFG_LRATE:  lrate = data[15:0];
        CFG_URATE:  urate = data[23:0];
        CFG_DBAND:  dband = data[30:0];
        CFG_WEIGHT: weight = data[23:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mag(longint d);
      return d < 0 ? -d : d;
    endfunction

    function bit [63:0] qsat(bit [127:0] n, bit [63:0] d);
      bit [127:0] q;
      if (d == 0) return SAT;
      q = n / d;
      return q > SAT ? SAT : q[63:0];
    endfunction

    function void note_pixel(int pred, int lab, bit ls, bit lb);
      int s, idx, num, n, k;
      longint d;
      longint sums[NSAMP];
      bit [63:0] ad, base, cth, hth, loss, v, sm, den, q;
      bit [127:0] dot, prod;
      int total_v;
      bit range_on, adjust_on, dbz;
      s = samp_cnt;
      if (s < NSAMP && sizes[s] < NPIX) begin
        idx = s * NPIX + sizes[s];
        d = longint'(pred) - longint'(lab);
        ad = mag(d);
        diffs[idx] = d;
        marks[idx] = lab >= min_lab && lab <= max_lab;
        if (marks[idx]) vcnt[s]++;
        sizes[s]++;
        if (ad > max_abs) max_abs = ad;
        abs_sum += ad;
        pix_cnt++;
      end
      if ((ls | lb) && s < NSAMP) samp_cnt++;
      if (!lb) return;

      num = samp_cnt;
      if (mode[MODE_AVG]) base = pix_cnt != 0 ? abs_sum / pix_cnt : 0;
      else base = max_abs;
      cth = (base * lrate) >> 16;
      hth = (base * urate) >> 16;
      range_on = mode[MODE_RANGE];
      adjust_on = range_on && mode[MODE_ADJUST];
      dot = 0;
      total_v = 0;
      dbz = 0;
      for (n = 0; n < num; n++) begin
        sums[n] = 0;
        for (k = 0; k < sizes[n]; k++) begin
          idx = n * NPIX + k;
          d = diffs[idx];
          if (range_on) begin
            ad = mag(d);
            if (!marks[idx]) d = 0;
            else if (ad <= cth) begin
              if (d > longint'(dband)) d = cth;
              else if (d < -longint'(dband)) d = -longint'(cth);
            end else if (mode[MODE_UPPER] && ad > hth) begin
              d = d > 0 ? longint'(hth) : -longint'(hth);
            end
          end
          dot += 128'(mag(d)) * 128'(mag(d));
          sums[n] += d;
        end
        total_v += adjust_on ? vcnt[n] : sizes[n];
      end
      if (total_v == 0) begin
        dbz = 1;
        loss = SAT;
      end else begin
        loss = qsat(dot, 2 * total_v);
        for (n = 0; n < num; n++) begin
          v = adjust_on ? vcnt[n] : sizes[n];
          if (v == 0) begin
            dbz = 1;
            break;
          end
          sm = mag(sums[n]);
          prod = 128'(sm) * 128'(sm) * 128'(weight);
          den = v * v * num * 131072;
          q = qsat(prod, den);
          loss = loss + q > SAT ? SAT : loss + q;
        end
        if (dbz) loss = SAT;
      end
      losses.push_back('{loss[62:0], total_v[15:0], dbz});
      clear();
    endfunction

    function void check_loss(bit [62:0] loss, bit [15:0] vt, bit dbz);
      batch_loss_t e;
      results++;
      if (dbz) dbz_seen++;
      if (losses.size() == 0) begin
        $error("unexpected result transaction: loss=%0d", loss);
        errors++;
        return;
      end
      e = losses.pop_front();
      if (e.loss !== loss) begin
        $error("loss: expected %0d, got %0d", e.loss, loss);
        errors++;
      end
      if (e.valid_total !== vt) begin
        $error("valid_total: expected %0d, got %0d", e.valid_total, vt);
        errors++;
      end
      if (e.dbz !== dbz) begin
        $error("divide_by_zero: expected %0d, got %0d", e.dbz, dbz);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  loss_scoreboard sb = new();
  bit quiet = 0;
  bit held = 0;
  int pixels_sent = 0;
  int batches_sent = 0;

  scale_invariant_berhu_loss dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_pixel(in_tdata[31:0], in_tdata[63:32], in_tlast, in_tuser[0]);
    if (rst_n && cfg_valid && cfg_ready)
      sb.configure(cfg_index, cfg_data);
    if (rst_n && out_tvalid && out_tready)
      sb.check_loss(out_tdata[62:0], out_tdata[78:63], out_tuser[0]);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!held && sb.results >= 10) begin
        held = 1;
        out_tready <= 0;
        repeat (3000) @(posedge clk);
      end else begin
        out_tready <= quiet || $urandom_range(0, 99) >= 12;
      end
    end
  end

  initial begin
    #20ms;
    $display("scale_invariant_berhu_loss_tb NOT OK");
    $finish;
  end

  task automatic send_pixel(int pred, int lab, bit ls, bit lb);
    in_tvalid <= 1;
    in_tdata <= {lab, pred};
    in_tlast <= ls;
    in_tuser <= lb;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    if (lb) batches_sent++;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.losses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic int pick_value(bit wild);
    case ($urandom_range(0, wild ? 3 : 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 0;
      default: return int'($urandom_range(0, 20 << 16)) - (8 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_extreme(logic [31:0] top);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return top;
      default: return $urandom & top;
    endcase
  endfunction

  task automatic configure_random();
    cfg_write(CFG_MODE, $urandom_range(0, 15));
    if ($urandom_range(0, 5) == 0) begin
      cfg_write(CFG_MIN, $urandom_range(0, 1) ? 32'h8000_0000 : $urandom);
      cfg_write(CFG_MAX, $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom);
    end else begin
      cfg_write(CFG_MIN, int'($urandom_range(0, 6 << 16)) - (5 << 16));
      cfg_write(CFG_MAX, int'($urandom_range(0, 12 << 16)) - (1 << 16));
    end
    cfg_write(CFG_LRATE, pick_extreme(32'hFFFF));
    cfg_write(CFG_URATE, pick_extreme(32'hFF_FFFF));
    cfg_write(CFG_DBAND, $urandom_range(0, 2) == 0 ? pick_extreme(32'h7FFF_FFFF)
                                                   : $urandom_range(0, 3 << 16));
    cfg_write(CFG_WEIGHT, pick_extreme(32'hFF_FFFF));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic run_batch(int nsamp, int maxpix, bit wild);
    int n, s, k;
    bit lb;
    for (s = 0; s < nsamp; s++) begin
      n = $urandom_range(1, maxpix);
      for (k = 0; k < n; k++) begin
        lb = s == nsamp - 1 && k == n - 1;
        send_pixel(pick_value(wild), pick_value(wild),
                   k == n - 1 && !(lb && $urandom_range(0, 3) == 0), lb);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes of both fields at reset settings
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 0);
    send_pixel(32'hFFFF_FFFF, 1, 1, 1);
    send_pixel(5 << 16, 3 << 16, 0, 1);
    drain();
    // range check with clamps and adjusted counts; an all-invalid sample
    cfg_write(CFG_MODE, 4'hF);
    cfg_write(CFG_URATE, 24'h01_8000);
    cfg_write(CFG_WEIGHT, 24'hFF_FFFF);
    cfg_valid <= 0;
    @(posedge clk);
    send_pixel(2 << 16, 1 << 16, 0, 0);
    send_pixel(9 << 16, 1 << 16, 1, 0);
    send_pixel(4 << 16, -3, 1, 1);
    send_pixel(7, 1 << 16, 1, 1);
    drain();
    // empty label range
    cfg_write(CFG_MIN, 32'h7FFF_FFFF);
    cfg_write(CFG_MAX, 32'h8000_0000);
    cfg_valid <= 0;
    @(posedge clk);
    send_pixel(1 << 16, 1 << 16, 0, 0);
    send_pixel(2 << 16, 0, 1, 1);
    drain();
    // too many samples: ten samples of one pixel
    for (int i = 0; i < 10; i++) send_pixel(pick_value(0), pick_value(0), 1, i == 9);
    drain();

    phase = 0;
    while (pixels_sent < 1550) begin
      configure_random();
      quiet = phase == 4;
      if (phase == 2) begin
        // sample full: one oversized sample
        for (int i = 0; i < NPIX + 4; i++)
          send_pixel(pick_value(0), pick_value(0), i == NPIX + 3, i == NPIX + 3);
      end
      repeat ($urandom_range(3, 8))
        run_batch($urandom_range(0, 9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8),
                  $urandom_range(1, 6), $urandom_range(0, 5) == 0);
      drain();
      quiet = 0;
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d pixels in %0d batches over %0d settings; %0d results, %0d divide-by-zero.",
             pixels_sent, batches_sent, phase + 3, sb.results, sb.dbz_seen);
    if (sb.errors == 0 && sb.losses.size() == 0) begin
      $display("scale_invariant_berhu_loss_tb OK");
    end else begin
      $display("scale_invariant_berhu_loss_tb NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/sibl_pkg.sv
rtl/sibl_store.sv
rtl/sibl_mul.sv
rtl/sibl_div.sv
rtl/scale_invariant_berhu_loss.sv
tb/scale_invariant_berhu_loss_tb.sv
